/* rtl/rss_pkg.sv */
`timescale 1ns / 1ps

package rss_pkg;

    // Default structure of the statistics engine.
    localparam int SAMPLE_BITS_DEF   = 24;
    localparam int COUNT_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 8;

    // Fixed widths of the channel fields.
    localparam int FUNC_W    = 1;
    localparam int SAMPLE_W  = 24;
    localparam int COUNT_W   = 16;
    localparam int MEAN_W    = 32;
    localparam int DEV_W     = 32;
    localparam int ROOT_IN_W = 64;

    // The square root runs one result bit per step over a 64-bit radicand.
    localparam int SQRT_STEPS = ROOT_IN_W / 2;

    localparam logic FUNC_RECORD = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_UPDATE,
        OP_ACCUM,
        OP_MULA_INIT,
        OP_MUL_STEP,
        OP_MULB_INIT,
        OP_DIVM_INIT,
        OP_DIV_STEP,
        OP_DIVD_INIT,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_OUT
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_ACCUM,
        ST_MULA_INIT,
        ST_MULA,
        ST_MULB_INIT,
        ST_MULB,
        ST_DIVM_INIT,
        ST_DIVM,
        ST_DIVD_INIT,
        ST_DIVD,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_stat_t;

endpackage

/* rtl/rss_ifs.sv */
`timescale 1ns / 1ps

interface rss_in_if import rss_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output func, output sample, input ready);
    modport sink (input valid, input func, input sample, output ready);
endinterface

interface rss_out_if import rss_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [COUNT_W-1:0]         count;
    logic signed [SAMPLE_W-1:0] minimum;
    logic signed [SAMPLE_W-1:0] maximum;
    logic signed [MEAN_W-1:0]   mean;
    logic [DEV_W-1:0]           deviation;
    logic                       dropped;

    modport source (output valid, output count, output minimum, output maximum,
                    output mean, output deviation, output dropped, input ready);
    modport sink (input valid, input count, input minimum, input maximum,
                  input mean, input deviation, input dropped, output ready);
endinterface

/* rtl/rss_ctrl.sv */
`timescale 1ns / 1ps

module rss_ctrl import rss_pkg::*; #(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    localparam int MULA_K = COUNT_BITS;
    localparam int MULB_K = SAMPLE_BITS + COUNT_BITS - 1;
    localparam int DIVM_K = MULB_K + FRACTION_BITS;
    localparam int DIVD_K = 2 * SAMPLE_BITS + 2 * COUNT_BITS - 2 + 2 * FRACTION_BITS;
    localparam int MAX_K  = (DIVD_K > SQRT_STEPS) ? DIVD_K : SQRT_STEPS;
    localparam int CNT_W  = $clog2(MAX_K);

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Each iterative phase loads the counter with its step count less one
    // and moves on once the counter has run down to zero.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.op     = OP_UPDATE;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.op     = OP_ACCUM;
                state_next = ST_MULA_INIT;
            end
            ST_MULA_INIT:
            begin
                cmd.op     = OP_MULA_INIT;
                cnt_next   = CNT_W'(MULA_K - 1);
                state_next = ST_MULA;
            end
            ST_MULA:
            begin
                cmd.op   = OP_MUL_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_MULB_INIT;
                end
            end
            ST_MULB_INIT:
            begin
                cmd.op     = OP_MULB_INIT;
                cnt_next   = CNT_W'(MULB_K - 1);
                state_next = ST_MULB;
            end
            ST_MULB:
            begin
                cmd.op   = OP_MUL_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DIVM_INIT;
                end
            end
            ST_DIVM_INIT:
            begin
                cmd.op     = OP_DIVM_INIT;
                cnt_next   = CNT_W'(DIVM_K - 1);
                state_next = ST_DIVM;
            end
            ST_DIVM:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DIVD_INIT;
                end
            end
            ST_DIVD_INIT:
            begin
                cmd.op     = OP_DIVD_INIT;
                cnt_next   = CNT_W'(DIVD_K - 1);
                state_next = ST_DIVD;
            end
            ST_DIVD:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_SQRT_INIT;
                end
            end
            ST_SQRT_INIT:
            begin
                cmd.op     = OP_SQRT_INIT;
                cnt_next   = CNT_W'(SQRT_STEPS - 1);
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.op   = OP_SQRT_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/rss_datapath.sv */
`timescale 1ns / 1ps

module rss_datapath import rss_pkg::*; #(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    input  dp_cmd_t                    cmd,
    output dp_stat_t                   stat,
    input  logic [FUNC_W-1:0]          in_func,
    input  logic signed [SAMPLE_W-1:0] in_sample,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [COUNT_W-1:0]         out_count,
    output logic signed [SAMPLE_W-1:0] out_minimum,
    output logic signed [SAMPLE_W-1:0] out_maximum,
    output logic signed [MEAN_W-1:0]   out_mean,
    output logic [DEV_W-1:0]           out_deviation,
    output logic                       out_dropped
);

    localparam int SB     = SAMPLE_BITS;
    localparam int CB     = COUNT_BITS;
    localparam int FB     = FRACTION_BITS;
    localparam int SUM_W  = SB + CB;
    localparam int MAG_W  = SUM_W - 1;
    localparam int SQ_W   = 2 * SB + CB - 2;
    localparam int SQR_W  = 2 * SB - 1;
    localparam int P_W    = 2 * SB + 2 * CB - 2;
    localparam int DIV_W  = P_W + 2 * FB;
    localparam int DV_W   = 2 * CB;
    localparam int MEAN_K = MAG_W + FB;
    localparam int EXT_W  = 2 * ROOT_IN_W;

    localparam logic signed [SB-1:0] SAMP_MAX = {1'b0, {(SB - 1){1'b1}}};
    localparam logic signed [SB-1:0] SAMP_MIN = {1'b1, {(SB - 1){1'b0}}};
    localparam logic [CB-1:0]        CNT_FULL = '1;

    logic                    mode_reg;
    logic                    func_reg;
    logic signed [SB-1:0]    samp_reg;
    logic [CB-1:0]           count_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]         sumsq_reg;
    logic signed [SB-1:0]    min_reg;
    logic signed [SB-1:0]    max_reg;
    logic [SQR_W-1:0]        sq_reg;
    logic                    add_reg;
    logic                    drop_reg;
    logic [DV_W-1:0]         nd_reg;
    logic [P_W-1:0]          ma_reg;
    logic [MAG_W-1:0]        mb_reg;
    logic [P_W-1:0]          acc_reg;
    logic [P_W-1:0]          proda_reg;
    logic [DV_W-1:0]         rem_reg;
    logic [DV_W-1:0]         dvsr_reg;
    logic [DIV_W-1:0]        qr_reg;
    logic [MEAN_W-1:0]       mean_reg;
    logic                    dzero_reg;
    logic [ROOT_IN_W-1:0]    sx_reg;
    logic [ROOT_IN_W-1:0]    sres_reg;
    logic [ROOT_IN_W-1:0]    sbit_reg;

    logic signed [2*SB-1:0]  sq_full;
    logic [CB-1:0]           dsel;
    logic [SUM_W-1:0]        sum_abs;
    logic [MAG_W-1:0]        mag;
    logic [DV_W:0]           div_cur;
    logic                    div_ge;
    logic [DV_W:0]           div_diff;
    logic [EXT_W-1:0]        q_ext;
    logic [MEAN_W-1:0]       q32;
    logic [ROOT_IN_W-1:0]    trial;

    assign sq_full  = samp_reg * samp_reg;
    assign dsel     = mode_reg ? (count_reg - 1'b1) : count_reg;
    assign sum_abs  = sum_reg[SUM_W-1] ? (SUM_W'(0) - sum_reg) : sum_reg;
    assign mag      = sum_abs[MAG_W-1:0];
    assign div_cur  = {rem_reg, qr_reg[DIV_W-1]};
    assign div_ge   = div_cur >= {1'b0, dvsr_reg};
    assign div_diff = div_cur - {1'b0, dvsr_reg};
    assign q_ext    = EXT_W'(qr_reg);
    assign q32      = q_ext[MEAN_W-1:0];
    assign trial    = sres_reg + sbit_reg;

    assign stat.out_busy = out_valid && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            min_reg   <= SAMP_MAX;
            max_reg   <= SAMP_MIN;
            sq_reg    <= '0;
            nd_reg    <= '0;
            add_reg   <= 1'b0;
            drop_reg  <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            case (cmd.op)
                OP_UPDATE:
                begin
                    add_reg  <= 1'b0;
                    drop_reg <= 1'b0;
                    sq_reg   <= sq_full[SQR_W-1:0];
                    if (func_reg == FUNC_CLEAR)
                    begin
                        count_reg <= '0;
                        sum_reg   <= '0;
                        sumsq_reg <= '0;
                        min_reg   <= SAMP_MAX;
                        max_reg   <= SAMP_MIN;
                    end
                    else if (count_reg == CNT_FULL)
                    begin
                        drop_reg <= 1'b1;
                    end
                    else
                    begin
                        add_reg   <= 1'b1;
                        count_reg <= count_reg + 1'b1;
                        sum_reg   <= sum_reg + SUM_W'(samp_reg);
                        if (samp_reg < min_reg)
                        begin
                            min_reg <= samp_reg;
                        end
                        if (samp_reg > max_reg)
                        begin
                            max_reg <= samp_reg;
                        end
                    end
                end
                OP_ACCUM:
                begin
                    if (add_reg)
                    begin
                        sumsq_reg <= sumsq_reg + SQ_W'(sq_reg);
                    end
                    nd_reg <= DV_W'(count_reg) * DV_W'(dsel);
                end
                OP_OUT:
                begin
                    out_valid <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Arithmetic working registers; no reset needed.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                func_reg <= in_func[0];
                samp_reg <= in_sample[SB-1:0];
            end
            OP_MULA_INIT:
            begin
                acc_reg <= '0;
                ma_reg  <= P_W'(sumsq_reg);
                mb_reg  <= MAG_W'(count_reg);
            end
            OP_MUL_STEP:
            begin
                if (mb_reg[0])
                begin
                    acc_reg <= acc_reg + ma_reg;
                end
                ma_reg <= ma_reg << 1;
                mb_reg <= mb_reg >> 1;
            end
            OP_MULB_INIT:
            begin
                proda_reg <= acc_reg;
                acc_reg   <= '0;
                ma_reg    <= P_W'(mag);
                mb_reg    <= mag;
            end
            OP_DIVM_INIT:
            begin
                rem_reg  <= '0;
                dvsr_reg <= DV_W'(count_reg);
                qr_reg   <= DIV_W'(mag) << (DIV_W - MEAN_K + FB);
            end
            OP_DIV_STEP:
            begin
                rem_reg <= div_ge ? div_diff[DV_W-1:0] : div_cur[DV_W-1:0];
                qr_reg  <= {qr_reg[DIV_W-2:0], div_ge};
            end
            OP_DIVD_INIT:
            begin
                if (count_reg == '0)
                begin
                    mean_reg <= '0;
                end
                else
                begin
                    mean_reg <= sum_reg[SUM_W-1] ? (MEAN_W'(0) - q32) : q32;
                end
                dzero_reg <= (count_reg == '0) || (mode_reg && count_reg < CB'(2))
                             || (proda_reg < acc_reg);
                rem_reg   <= '0;
                dvsr_reg  <= nd_reg;
                qr_reg    <= DIV_W'(proda_reg - acc_reg) << (2 * FB);
            end
            OP_SQRT_INIT:
            begin
                sx_reg   <= (q_ext[EXT_W-1:ROOT_IN_W] != '0) ? '1 : q_ext[ROOT_IN_W-1:0];
                sres_reg <= '0;
                sbit_reg <= ROOT_IN_W'(1) << (ROOT_IN_W - 2);
            end
            OP_SQRT_STEP:
            begin
                if (sx_reg >= trial)
                begin
                    sx_reg   <= sx_reg - trial;
                    sres_reg <= (sres_reg >> 1) + sbit_reg;
                end
                else
                begin
                    sres_reg <= sres_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
            end
            OP_OUT:
            begin
                out_count     <= COUNT_W'(count_reg);
                out_minimum   <= SAMPLE_W'(min_reg);
                out_maximum   <= SAMPLE_W'(max_reg);
                out_mean      <= mean_reg;
                out_deviation <= dzero_reg ? '0 : sres_reg[DEV_W-1:0];
                out_dropped   <= drop_reg;
            end
            default:
            begin
            end
        endcase
    end

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |-> min_reg <= max_reg)
        else $error("running minimum above running maximum");

    a_empty_sums: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> (sum_reg == '0 && sumsq_reg == '0))
        else $error("sums not zero with no samples held");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT && drop_reg) |-> count_reg == CNT_FULL)
        else $error("sample dropped while count not full");

endmodule

/* rtl/running_sample_statistics_unit.sv */
`timescale 1ns / 1ps

// Running sample statistics. Each input beat either records a signed sample
// (func = 0) or clears the accumulators (func = 1), and each input beat gives
// exactly one output beat with the count, minimum, maximum, mean and standard
// deviation of the samples held after it. Mean and deviation carry
// FRACTION_BITS fraction bits; the mean is truncated toward zero and the
// deviation is the floor of an exact integer square root. Once the count is
// full a record beat changes nothing and reports dropped = 1. The single
// configuration bit selects population (0) or sample (1) deviation and may be
// written only while the unit is idle. One item is processed at a time: the
// unit takes no new input beat until the current item is done, and that
// includes waiting for the previous result to be taken. The work runs
// through the shared bit-serial shift-add multiplier (n times sum of
// squares, then sum squared), the shared restoring divider (mean, then
// variance) and the 32-step square root, all run one after another by the
// controller.
module running_sample_statistics_unit import rss_pkg::*; #(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    rss_in_if.sink    in_ch,
    rss_out_if.source out_ch
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The controller sequences the phases; the datapath owns all data state.
    rss_ctrl #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .COUNT_BITS    (COUNT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // The result register in the datapath holds a finished beat until the
    // sink takes it, so the next input beat can be accepted meanwhile.
    rss_datapath #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .COUNT_BITS    (COUNT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .cmd           (cmd),
        .stat          (stat),
        .in_func       (in_ch.func),
        .in_sample     (in_ch.sample),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .out_count     (out_ch.count),
        .out_minimum   (out_ch.minimum),
        .out_maximum   (out_ch.maximum),
        .out_mean      (out_ch.mean),
        .out_deviation (out_ch.deviation),
        .out_dropped   (out_ch.dropped)
    );

    // Only one item is in flight, so an accepted beat closes the input.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input accepted while an item is in progress");

    // A new result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT) |-> !(out_ch.valid && !out_ch.ready))
        else $error("result loaded over a pending output beat");

    // Results are only produced while no input can be taken.
    a_out_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT) |-> !in_ch.ready)
        else $error("result produced while idle");

endmodule
